### design/bdaf_pkg.sv
// Package: shared constants, types and command/status structs for the decimal field unit
`timescale 1ns / 1ps

package bdaf_pkg;

   // Input binary width and decimal digit storage
   localparam int BIN_WIDTH   = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int BCD_WIDTH   = 4 * DIGIT_COUNT;

   // Configuration register
   localparam int          FIELD_WIDTH_BITS = 5;
   localparam logic [4:0]  FIELD_WIDTH_RESET = 5'd11;
   localparam logic [4:0]  FIELD_WIDTH_MIN   = 5'd2;

   // Default for the top-level field size limit
   localparam int MAX_FIELD_WIDTH_DEFAULT = 16;

   // Character codes
   localparam int         CHAR_BITS  = 8;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_NUL   = 8'd0;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_EMIT    = 3'b100
   } bdaf_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic shift;
      logic emit;
   } bdaf_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic conv_last;
      logic emit_last;
   } bdaf_status_type;

endpackage

### design/bdaf_ctrl.sv
// Controller: sequences load, binary-to-BCD conversion and character emission
`timescale 1ns / 1ps

module bdaf_ctrl
   import bdaf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  bdaf_status_type status,
   output bdaf_cmd_type    cmd,
   output logic            busy
);

   bdaf_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.shift = 1'b0;
      cmd.emit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### design/bdaf_dpath.sv
// Datapath: field width register, shift-add-3 converter and character output register
`timescale 1ns / 1ps

module bdaf_dpath
   import bdaf_pkg::*;
#(
   parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  bdaf_cmd_type                cmd,
   output bdaf_status_type             status,
   input  logic [BIN_WIDTH-1:0]        req_value,
   input  logic                        csr_write_enable,
   input  logic [FIELD_WIDTH_BITS-1:0] csr_write_data,
   output logic                        rsp_valid,
   output logic [CHAR_BITS-1:0]        rsp_char_code,
   output logic                        rsp_last_char,
   output logic                        rsp_truncated
);

   // The register cannot exceed its own range, so clamp the limit to it
   localparam int FieldMax = (1 << FIELD_WIDTH_BITS) - 1;
   localparam int MaxW     = (MAX_FIELD_WIDTH > FieldMax) ? FieldMax : MAX_FIELD_WIDTH;
   localparam int PosW     = (MaxW > 2) ? $clog2(MaxW) : 1;
   localparam int CntW     = $clog2(BIN_WIDTH);
   localparam logic [FIELD_WIDTH_BITS-1:0] MaxWLim = FIELD_WIDTH_BITS'(MaxW);
   localparam logic [CntW-1:0]             CntLast = CntW'(BIN_WIDTH - 1);

   logic [FIELD_WIDTH_BITS-1:0] field_width_ff;
   logic [BCD_WIDTH-1:0]        bcd_ff, bcd_in;
   logic [BIN_WIDTH-1:0]        bin_ff;
   logic [CntW-1:0]             cnt_ff;
   logic [PosW-1:0]             rem_ff;
   logic [PosW-1:0]             places_ff;
   logic [FIELD_WIDTH_BITS-1:0] eff_width;
   logic [BCD_WIDTH-1:0]        bcd_adj;
   logic [3:0]                  ndigits;
   logic [PosW-1:0]             digit_idx;
   logic [3:0]                  digit_sel;
   logic                        trunc;
   logic [CHAR_BITS-1:0]        char_in;
   logic                        last_in;
   logic                        rsp_valid_ff;
   logic [CHAR_BITS-1:0]        rsp_char_ff;
   logic                        rsp_last_ff;
   logic                        rsp_trunc_ff;

   // Write the field width register
   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= FIELD_WIDTH_RESET;
      end else if (csr_write_enable) begin
         field_width_ff <= csr_write_data;
      end
   end

   // Clamp the field width into the supported range
   always_comb begin
      if (field_width_ff < FIELD_WIDTH_MIN) begin
         eff_width = FIELD_WIDTH_MIN;
      end else if (field_width_ff > MaxWLim) begin
         eff_width = MaxWLim;
      end else begin
         eff_width = field_width_ff;
      end
   end

   // Add 3 to every BCD digit of five or more, then shift in the next binary bit
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
      bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
   end

   // Load, convert and count down the character positions
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff    <= req_value;
         bcd_ff    <= '0;
         cnt_ff    <= '0;
         rem_ff    <= PosW'(eff_width - 5'd1);
         places_ff <= PosW'(eff_width - 5'd1);
      end else if (cmd.shift) begin
         bin_ff <= {bin_ff[BIN_WIDTH-2:0], 1'b0};
         bcd_ff <= bcd_in;
         cnt_ff <= cnt_ff + CntW'(1);
      end else if (cmd.emit) begin
         rem_ff <= rem_ff - PosW'(1);
      end
   end

   assign status.conv_last = (cnt_ff == CntLast);
   assign status.emit_last = (rem_ff == '0);

   // Count significant digits; zero still prints one digit
   always_comb begin
      ndigits = 4'd1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (bcd_ff[4*k +: 4] != 4'd0) begin
            ndigits = 4'(k + 1);
         end
      end
   end

   assign trunc = (32'(ndigits) > 32'(places_ff));

   // Pick the digit for the current place
   assign digit_idx = rem_ff - PosW'(1);
   always_comb begin
      digit_sel = 4'd0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (32'(digit_idx) == k) begin
            digit_sel = bcd_ff[4*k +: 4];
         end
      end
   end

   // Form the character: NUL at the end, digit where significant, space before
   always_comb begin
      last_in = 1'b0;
      if (rem_ff == '0) begin
         char_in = CHAR_NUL;
         last_in = 1'b1;
      end else if (32'(digit_idx) < 32'(ndigits)) begin
         char_in = CHAR_ZERO + {4'd0, digit_sel};
      end else begin
         char_in = CHAR_SPACE;
      end
   end

   // Register the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   // Register the response payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_char_ff  <= char_in;
         rsp_last_ff  <= last_in;
         rsp_trunc_ff <= trunc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

endmodule

### design/binary_to_decimal_ascii_field_unit.sv
// Top level: unsigned 32-bit value to right-aligned decimal ASCII field
//
//   Channel   Ports                                    Handshake
//   request   req_value                                start & !busy
//   response  rsp_char_code, rsp_last_char,            rsp_valid, one cycle each
//             rsp_truncated
//   config    csr_write_data                           csr_write_enable
//
// After a request is accepted, the BCD converter runs its 32 shift-add-3
// steps, then the output register gives the W characters of the field, one
// character per cycle, W being the clamped field width. The last character
// is shown in the same cycle that busy falls. Reset is synchronous and sets
// the field width to 11. The receiver cannot stall; every character is
// presented once for one cycle.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_field_unit
   import bdaf_pkg::*;
#(
   parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEFAULT
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [BIN_WIDTH-1:0]        req_value,
   input  logic                        csr_write_enable,
   input  logic [FIELD_WIDTH_BITS-1:0] csr_write_data,
   output logic                        rsp_valid,
   output logic [CHAR_BITS-1:0]        rsp_char_code,
   output logic                        rsp_last_char,
   output logic                        rsp_truncated
);

   bdaf_cmd_type    cmd;
   bdaf_status_type status;

   // Sequence the request
   bdaf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Convert and emit
   bdaf_dpath #(
      .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_char_code    (rsp_char_code),
      .rsp_last_char    (rsp_last_char),
      .rsp_truncated    (rsp_truncated)
   );

endmodule
